>>> design/assert_macros.svh
// Assertion macros used by the datapath RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> design/glsbfs_pkg.sv
// Types, constants and codes shared by the level walk core.
`default_nettype none
package glsbfs_pkg;

  localparam int MAX_NODES = 1024;
  localparam int MAX_EDGES = 8192;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int EDGE_AW   = $clog2(MAX_EDGES);
  localparam int CNT_W     = NODE_W + 1;
  localparam int TOT_W     = 14;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_RUN    = 2'd2;
  localparam logic [1:0] REQ_NOP    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ORDER     = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_BAD_START = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [NODE_W-1:0] edge_row;
    logic [NODE_W-1:0] edge_col;
    logic [NODE_W-1:0] start_node;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [TOT_W-1:0]  edge_total;
    logic [CNT_W-1:0]  level_count;
    logic [NODE_W-1:0] max_width;
    logic [NODE_W-1:0] end_node;
    logic              end_found;
  } res_t;

  typedef struct packed {
    logic append;
    logic nop_res;
    logic bad_run;
    logic clear_go;
    logic clear_done;
    logic run_go;
    logic sweep_deg;
    logic sweep_vis;
    logic init;
    logic deg_eval;
    logic vis_eval;
    logic next_node;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic bad_start;
    logic deg_zero;
    logic last_edge;
    logic last_node;
    logic walk_done;
  } sts_t;

endpackage
`default_nettype wire

>>> design/graph_level_structure_bfs_core.sv
// Edge results are registered; one edge is taken per cycle while busy is low. Clear
// sweeps the degree table, then answers. Run: visited-mark clear, setup, then
// FADDR, NODE, DEG per frontier node and EADDR, TGT, VIS per stored edge of visited
// rows; busy is high throughout. Bad start or unknown request answers in the next
// cycle. Results are a one-cycle done_o strobe and cannot be stalled. Reset clears
// the degree table (busy high); configuration writes are taken at any time.
`default_nettype none
module graph_level_structure_bfs_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire glsbfs_pkg::req_t             req_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [glsbfs_pkg::CNT_W-1:0] cfg_wdata_i,
  output logic                              done_o,
  output glsbfs_pkg::res_t                  res_o
);
  import glsbfs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  glsbfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_type_i (req_i.req_type),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  glsbfs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .done_o      (done_o),
    .res_o       (res_o)
  );

endmodule
`default_nettype wire

>>> design/glsbfs_ctrl.sv
// Controller state machine of the level walk core.
`default_nettype none
module glsbfs_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [1:0]       req_type_i,
  input  wire glsbfs_pkg::sts_t sts_i,
  output glsbfs_pkg::cmd_t      cmd_o,
  output logic                  busy_o
);
  import glsbfs_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RCLR  = 4'd1;
  localparam logic [3:0] S_DCLR  = 4'd2;
  localparam logic [3:0] S_VCLR  = 4'd3;
  localparam logic [3:0] S_INIT  = 4'd4;
  localparam logic [3:0] S_FADDR = 4'd5;
  localparam logic [3:0] S_NODE  = 4'd6;
  localparam logic [3:0] S_DEG   = 4'd7;
  localparam logic [3:0] S_EADDR = 4'd8;
  localparam logic [3:0] S_TGT   = 4'd9;
  localparam logic [3:0] S_VIS   = 4'd10;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RCLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (req_type_i)
            REQ_CLEAR: begin
              cmd_o.clear_go = 1'b1;
              state_d        = S_DCLR;
            end
            REQ_APPEND: cmd_o.append = 1'b1;
            REQ_RUN: begin
              if (sts_i.bad_start) begin
                cmd_o.bad_run = 1'b1;
              end else begin
                cmd_o.run_go = 1'b1;
                state_d      = S_VCLR;
              end
            end
            default: cmd_o.nop_res = 1'b1;
          endcase
        end
      end
      S_RCLR: begin
        cmd_o.sweep_deg = 1'b1;
        if (sts_i.sweep_last) state_d = S_IDLE;
      end
      S_DCLR: begin
        cmd_o.sweep_deg = 1'b1;
        if (sts_i.sweep_last) begin
          cmd_o.clear_done = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_VCLR: begin
        cmd_o.sweep_vis = 1'b1;
        if (sts_i.sweep_last) state_d = S_INIT;
      end
      S_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = S_FADDR;
      end
      S_FADDR: state_d = S_NODE;
      S_NODE:  state_d = S_DEG;
      S_DEG: begin
        cmd_o.deg_eval = 1'b1;
        if (sts_i.deg_zero) begin
          cmd_o.next_node = 1'b1;
          state_d = (sts_i.last_node && sts_i.walk_done) ? S_IDLE : S_FADDR;
        end else begin
          state_d = S_EADDR;
        end
      end
      S_EADDR: state_d = S_TGT;
      S_TGT:   state_d = S_VIS;
      S_VIS: begin
        cmd_o.vis_eval = 1'b1;
        if (sts_i.last_edge) begin
          cmd_o.next_node = 1'b1;
          state_d = (sts_i.last_node && sts_i.walk_done) ? S_IDLE : S_FADDR;
        end else begin
          state_d = S_EADDR;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule
`default_nettype wire

>>> design/glsbfs_dp.sv
// Datapath of the level walk core: graph tables, walk counters, result register.
`default_nettype none
`include "assert_macros.svh"
module glsbfs_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire glsbfs_pkg::req_t             req_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [glsbfs_pkg::CNT_W-1:0] cfg_wdata_i,
  input  wire glsbfs_pkg::cmd_t             cmd_i,
  output glsbfs_pkg::sts_t                  sts_o,
  output logic                              done_o,
  output glsbfs_pkg::res_t                  res_o
);
  import glsbfs_pkg::*;

  localparam logic [CNT_W-1:0] NODES_C = CNT_W'(MAX_NODES);
  localparam logic [TOT_W-1:0] EDGES_C = TOT_W'(MAX_EDGES);

  // memories
  logic [NODE_W-1:0]  edge_mem  [MAX_EDGES];
  logic [EDGE_AW-1:0] first_mem [MAX_NODES];
  logic [CNT_W-1:0]   deg_mem   [MAX_NODES];
  logic               vis_mem   [MAX_NODES];
  logic [NODE_W-1:0]  front_mem [MAX_NODES];

  logic [NODE_W-1:0]  tgt_rd_q, f_rd_q;
  logic [EDGE_AW-1:0] first_rd_q;
  logic [CNT_W-1:0]   deg_rd_q;
  logic               vis_rd_q;

  logic [CNT_W-1:0]  node_count_q;
  logic [TOT_W-1:0]  stored_q;
  logic [NODE_W-1:0] prev_row_q;
  logic [CNT_W-1:0]  prev_col_q;
  logic [CNT_W-1:0]  cur_deg_q;
  logic [NODE_W-1:0] sweep_q;
  logic [NODE_W-1:0] start_q;
  logic [CNT_W-1:0]  i_q, hi_q, tail_q, levels_q, cnt_q, least_q;
  logic [NODE_W-1:0] widest_q, end_q;
  logic              found_q;
  logic [EDGE_AW-1:0] e_q;
  logic              done_q;
  res_t              res_q;

  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  row_x, col_x;
  logic              app_range, app_order, app_ok, new_row;
  logic [CNT_W-1:0]  new_deg;
  logic              add_node;
  logic [CNT_W-1:0]  tail_nx, least_nx, width;
  logic [NODE_W-1:0] end_nx;
  logic              found_nx;

  assign lim   = (node_count_q > NODES_C) ? NODES_C : node_count_q;
  assign row_x = {1'b0, req_i.edge_row};
  assign col_x = {1'b0, req_i.edge_col};

  assign app_range = (row_x >= lim) || (col_x >= lim) || (stored_q >= EDGES_C);
  assign app_order = (stored_q != '0) &&
                     ((req_i.edge_row < prev_row_q) ||
                      ((req_i.edge_row == prev_row_q) && (col_x <= prev_col_q)));
  assign app_ok  = cmd_i.append && !app_range && !app_order;
  // rows arrive in order, so a row change starts a fresh degree count
  assign new_row = (stored_q == '0) || (req_i.edge_row != prev_row_q);
  assign new_deg = new_row ? CNT_W'(1) : cur_deg_q + CNT_W'(1);

  assign add_node = cmd_i.vis_eval && !vis_rd_q && ({1'b0, tgt_rd_q} < lim);
  assign tail_nx  = tail_q + CNT_W'(add_node);
  assign width    = tail_nx - hi_q;

  always_comb begin
    least_nx = least_q;
    end_nx   = end_q;
    found_nx = found_q;
    if (cmd_i.deg_eval && (deg_rd_q < least_q)) begin
      least_nx = deg_rd_q;
      end_nx   = f_rd_q;
      found_nx = 1'b1;
    end
  end

  assign sts_o.sweep_last = (sweep_q == NODE_W'(MAX_NODES - 1));
  assign sts_o.bad_start  = ({1'b0, req_i.start_node} >= lim);
  assign sts_o.deg_zero   = (deg_rd_q == '0);
  assign sts_o.last_edge  = (cnt_q == CNT_W'(1));
  assign sts_o.last_node  = ((i_q + CNT_W'(1)) == hi_q);
  assign sts_o.walk_done  = (tail_nx == hi_q);

  // edge target store
  always_ff @(posedge clk_i) begin
    if (app_ok) edge_mem[stored_q[EDGE_AW-1:0]] <= req_i.edge_col;
    tgt_rd_q <= edge_mem[e_q];
  end

  // row tables
  always_ff @(posedge clk_i) begin
    if (app_ok && new_row) first_mem[req_i.edge_row] <= stored_q[EDGE_AW-1:0];
    first_rd_q <= first_mem[f_rd_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_deg) begin
      deg_mem[sweep_q] <= '0;
    end else if (app_ok) begin
      deg_mem[req_i.edge_row] <= new_deg;
    end
    deg_rd_q <= deg_mem[f_rd_q];
  end

  // visited marks
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_vis) begin
      vis_mem[sweep_q] <= 1'b0;
    end else if (cmd_i.init) begin
      vis_mem[start_q] <= 1'b1;
    end else if (add_node) begin
      vis_mem[tgt_rd_q] <= 1'b1;
    end
    vis_rd_q <= vis_mem[tgt_rd_q];
  end

  // frontier queue
  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      front_mem[0] <= start_q;
    end else if (add_node) begin
      front_mem[tail_q[NODE_W-1:0]] <= tgt_rd_q;
    end
    f_rd_q <= front_mem[i_q[NODE_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODES_C;
      stored_q     <= '0;
      prev_row_q   <= '0;
      prev_col_q   <= '0;
      cur_deg_q    <= '0;
      sweep_q      <= '0;
      start_q      <= '0;
      i_q          <= '0;
      hi_q         <= '0;
      tail_q       <= '0;
      levels_q     <= '0;
      cnt_q        <= '0;
      least_q      <= '0;
      widest_q     <= '0;
      end_q        <= '0;
      found_q      <= 1'b0;
      e_q          <= '0;
      done_q       <= 1'b0;
      res_q        <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) node_count_q <= cfg_wdata_i;

      if (cmd_i.sweep_deg || cmd_i.sweep_vis) sweep_q <= sweep_q + NODE_W'(1);
      if (cmd_i.clear_go || cmd_i.run_go) sweep_q <= '0;

      // root is held for the walk; the request lines may move after the transfer
      if (cmd_i.run_go) start_q <= req_i.start_node;

      if (cmd_i.clear_go) begin
        stored_q   <= '0;
        prev_row_q <= '0;
        prev_col_q <= '0;
      end

      if (cmd_i.append) begin
        done_q <= 1'b1;
        res_q  <= '0;
        if (app_range) begin
          res_q.status     <= ST_RANGE;
          res_q.edge_total <= stored_q;
        end else if (app_order) begin
          res_q.status     <= ST_ORDER;
          res_q.edge_total <= stored_q;
        end else begin
          res_q.status     <= ST_OK;
          res_q.edge_total <= stored_q + TOT_W'(1);
          stored_q         <= stored_q + TOT_W'(1);
          prev_row_q       <= req_i.edge_row;
          prev_col_q       <= col_x;
          cur_deg_q        <= new_deg;
        end
      end

      if (cmd_i.nop_res || cmd_i.bad_run || cmd_i.clear_done) begin
        done_q           <= 1'b1;
        res_q            <= '0;
        res_q.status     <= cmd_i.bad_run ? ST_BAD_START : ST_OK;
        res_q.edge_total <= stored_q;
      end

      if (cmd_i.init) begin
        i_q      <= '0;
        hi_q     <= CNT_W'(1);
        tail_q   <= CNT_W'(1);
        levels_q <= CNT_W'(1);
        widest_q <= '0;
        least_q  <= node_count_q;
        end_q    <= '0;
        found_q  <= 1'b0;
      end

      if (cmd_i.deg_eval) begin
        cnt_q   <= deg_rd_q;
        e_q     <= first_rd_q;
        least_q <= least_nx;
        end_q   <= end_nx;
        found_q <= found_nx;
      end

      if (cmd_i.vis_eval) begin
        tail_q <= tail_nx;
        cnt_q  <= cnt_q - CNT_W'(1);
        e_q    <= e_q + EDGE_AW'(1);
      end

      if (cmd_i.next_node) begin
        i_q <= i_q + CNT_W'(1);
        if (sts_o.last_node) begin
          if (sts_o.walk_done) begin
            done_q            <= 1'b1;
            res_q.status      <= ST_OK;
            res_q.edge_total  <= stored_q;
            res_q.level_count <= levels_q;
            res_q.max_width   <= widest_q;
            res_q.end_node    <= end_nx;
            res_q.end_found   <= found_nx;
          end else begin
            // level finished with new nodes: open the next level
            levels_q <= levels_q + CNT_W'(1);
            if (width > {1'b0, widest_q}) widest_q <= width[NODE_W-1:0];
            hi_q    <= tail_nx;
            least_q <= node_count_q;
            end_q   <= '0;
            found_q <= 1'b0;
          end
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  `ASSERT_HOLDS(a_vis_has_edge, clk_i, rst_ni, cmd_i.vis_eval |-> (cnt_q != '0), "edge count underflow")
  `ASSERT_HOLDS(a_node_in_level, clk_i, rst_ni, cmd_i.deg_eval |-> (i_q < hi_q), "node index past level end")
  `ASSERT_NEVER(a_tail_bound, clk_i, rst_ni, tail_q > NODES_C, "frontier overflow")
  `ASSERT_HOLDS(a_level_grows, clk_i, rst_ni, (cmd_i.next_node && sts_o.last_node && !sts_o.walk_done) |-> (tail_nx > hi_q), "empty level opened")

endmodule
`default_nettype wire

>>> test/graph_level_structure_bfs_core_tb.sv
// Testbench for the level walk core: loads graphs and checks every result against a predictor.
`timescale 1ns / 1ps
module graph_level_structure_bfs_core_tb;
  import glsbfs_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CNT_W-1:0] cfg_wdata_i = '0;
  req_t             req_i = '0;
  logic             busy;
  logic             done_o;
  res_t             res_o;

  graph_level_structure_bfs_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i), .done_o(done_o), .res_o(res_o)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  int unsigned node_cnt = 1024;
  int unsigned edge_dst[MAX_EDGES];
  int unsigned row_base[MAX_NODES];
  int unsigned row_deg[MAX_NODES];
  bit          seen[MAX_NODES];
  int unsigned level_q[MAX_NODES];
  int unsigned n_edges = 0;
  int unsigned last_row = 0;
  int unsigned last_col = 0;

  res_t        walk_q[$];
  res_t        want;
  int          errors = 0;
  int          idle_pct = 0;
  longint      cycles = 0;

  function automatic res_t predict_result(req_t r);
    res_t        o;
    int unsigned lim, lo, hi, tail, levels, widest, least, nd, e, t, i, k;
    o = '0;
    lim = (node_cnt < MAX_NODES) ? node_cnt : MAX_NODES;
    case (r.req_type)
      REQ_CLEAR: begin
        n_edges = 0;
        foreach (row_deg[j]) row_deg[j] = 0;
        last_row = 0;
        last_col = 0;
      end
      REQ_APPEND: begin
        if (r.edge_row >= lim || r.edge_col >= lim || n_edges >= MAX_EDGES)
          o.status = ST_RANGE;
        else if (n_edges > 0 && (r.edge_row < last_row ||
                 (r.edge_row == last_row && r.edge_col <= last_col)))
          o.status = ST_ORDER;
        else begin
          if (row_deg[r.edge_row] == 0) row_base[r.edge_row] = n_edges;
          row_deg[r.edge_row]++;
          edge_dst[n_edges] = r.edge_col;
          n_edges++;
          last_row = r.edge_row;
          last_col = r.edge_col;
        end
      end
      REQ_RUN: begin
        if (r.start_node >= lim) begin
          o.status = ST_BAD_START;
        end else begin
          foreach (seen[j]) seen[j] = 1'b0;
          seen[r.start_node] = 1'b1;
          level_q[0] = r.start_node;
          lo = 0; hi = 1; tail = 1; levels = 1; widest = 0;
          forever begin
            for (i = lo; i < hi; i++) begin
              nd = level_q[i];
              for (k = 0; k < row_deg[nd]; k++) begin
                e = row_base[nd] + k;
                if (e >= n_edges || e >= MAX_EDGES) break;
                t = edge_dst[e];
                if (t >= lim || seen[t]) continue;
                seen[t] = 1'b1;
                if (tail < MAX_NODES) begin
                  level_q[tail] = t;
                  tail++;
                end
              end
            end
            if (tail == hi) break;
            levels++;
            if (tail - hi > widest) widest = tail - hi;
            lo = hi;
            hi = tail;
          end
          // first node of strictly least degree wins
          least = node_cnt;
          for (i = lo; i < hi; i++) begin
            if (row_deg[level_q[i]] < least) begin
              least = row_deg[level_q[i]];
              o.end_node = NODE_W'(level_q[i]);
              o.end_found = 1'b1;
            end
          end
          o.level_count = CNT_W'(levels);
          o.max_width = NODE_W'(widest);
        end
      end
      default: ;
    endcase
    o.edge_total = TOT_W'(n_edges);
    return o;
  endfunction

  function automatic req_t mk_req(logic [1:0] kind, int unsigned row, int unsigned col,
                                  int unsigned root);
    req_t r;
    r.req_type = kind;
    r.edge_row = NODE_W'(row);
    r.edge_col = NODE_W'(col);
    r.start_node = NODE_W'(root);
    return r;
  endfunction

  task automatic report(string msg);
    errors++;
    if (errors < 50) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // call right after a rising edge; returns at the transfer edge or after an idle gap
  task automatic send_req(req_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    walk_q = {walk_q, predict_result(r)};
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (walk_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_nodes(int unsigned v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= CNT_W'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    node_cnt = v;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (walk_q.size() == 0) begin
        report("result with none expected");
      end else begin
        want = walk_q.pop_front();
        if (res_o.status !== want.status)
          report($sformatf("status %0d, want %0d", res_o.status, want.status));
        if (res_o.edge_total !== want.edge_total)
          report($sformatf("edge_total %0d, want %0d", res_o.edge_total, want.edge_total));
        if (res_o.level_count !== want.level_count)
          report($sformatf("level_count %0d, want %0d", res_o.level_count,
                           want.level_count));
        if (res_o.max_width !== want.max_width)
          report($sformatf("max_width %0d, want %0d", res_o.max_width, want.max_width));
        if (res_o.end_node !== want.end_node)
          report($sformatf("end_node %0d, want %0d", res_o.end_node, want.end_node));
        if (res_o.end_found !== want.end_found)
          report($sformatf("end_found %0d, want %0d", res_o.end_found, want.end_found));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 4000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    send_req(mk_req(REQ_NOP, 1023, 1023, 1023));     // unknown request
    send_req(mk_req(REQ_RUN, 0, 0, 0));              // empty graph
    send_req(mk_req(REQ_RUN, 0, 0, 1023));
    send_req(mk_req(REQ_APPEND, 0, 1, 0));
    send_req(mk_req(REQ_APPEND, 0, 1, 0));           // duplicate
    send_req(mk_req(REQ_APPEND, 1, 0, 0));
    send_req(mk_req(REQ_APPEND, 1, 1023, 0));
    send_req(mk_req(REQ_APPEND, 1023, 0, 0));
    send_req(mk_req(REQ_APPEND, 0, 5, 0));           // row goes backward
    send_req(mk_req(REQ_RUN, 0, 0, 0));
    send_req(mk_req(REQ_RUN, 0, 0, 1023));
    set_nodes(1);
    send_req(mk_req(REQ_RUN, 0, 0, 0));              // stale edges skipped
    send_req(mk_req(REQ_RUN, 0, 0, 1));              // bad start
    send_req(mk_req(REQ_APPEND, 0, 0, 0));           // in range, out of order
    send_req(mk_req(REQ_APPEND, 1, 0, 0));           // out of range
    send_req(mk_req(REQ_CLEAR, 0, 0, 0));
    send_req(mk_req(REQ_APPEND, 0, 0, 0));
    send_req(mk_req(REQ_RUN, 0, 0, 0));              // degree 1 not below 1: no end node
    set_nodes(1024);
    send_req(mk_req(REQ_APPEND, 2, 3, 0));
    send_req(mk_req(REQ_APPEND, 3, 2, 0));
    send_req(mk_req(REQ_RUN, 0, 0, 2));
    set_nodes(3);
    send_req(mk_req(REQ_RUN, 0, 0, 2));
    send_req(mk_req(REQ_CLEAR, 0, 0, 0));
  endtask

  task automatic test_full_store();
    set_nodes(1024);
    send_req(mk_req(REQ_CLEAR, 0, 0, 0));
    for (int r = 0; r < MAX_NODES; r++)
      for (int k = 0; k < 8; k++)
        send_req(mk_req(REQ_APPEND, r, k * 128 + (r + 1) % 128, 0));
    send_req(mk_req(REQ_APPEND, 1023, 1023, 0));     // store full
    send_req(mk_req(REQ_RUN, 0, 0, 0));
    send_req(mk_req(REQ_RUN, 0, 0, 1023));
    send_req(mk_req(REQ_CLEAR, 0, 0, 0));
  endtask

  task automatic test_random(int budget);
    int          sent;
    int unsigned nc, lim, r, c, dg, step;
    sent = 0;
    while (sent < budget) begin
      case ($urandom_range(0, 9))
        0:       nc = 1;
        1, 2:    nc = 1024;
        default: nc = $urandom_range(2, 40);
      endcase
      set_nodes(nc);
      lim = nc;
      send_req(mk_req(REQ_CLEAR, 0, 0, 0));
      sent++;
      r = 0;
      step = (lim > 64) ? lim / 20 : 1;
      while (r < lim && sent < budget) begin
        dg = $urandom_range(0, 3);
        c = $urandom_range(0, 2);
        for (int k = 0; k < dg && c < lim; k++) begin
          send_req(mk_req(REQ_APPEND, r, c, $urandom_range(0, 1023)));
          sent++;
          c += $urandom_range(1, (lim > 8) ? lim / 3 : 2);
        end
        if ($urandom_range(0, 9) == 0) begin
          // noise: random append or unknown request
          send_req(mk_req($urandom_range(0, 1) ? REQ_APPEND : REQ_NOP, $urandom_range(0, 1023),
                          $urandom_range(0, 1023), $urandom_range(0, 1023)));
          sent++;
        end
        r += $urandom_range(1, step);
      end
      repeat (3) begin
        send_req(mk_req(REQ_RUN, $urandom_range(0, 1023), $urandom_range(0, 1023),
                        ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                                    : $urandom_range(0, lim - 1)));
        sent++;
      end
      if ($urandom_range(0, 3) == 0) begin
        set_nodes($urandom_range(1, lim));
        repeat (2) begin
          send_req(mk_req(REQ_RUN, 0, 0, $urandom_range(0, lim - 1)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_store();
    idle_pct = 33;
    test_random(300);
    idle_pct = 53;
    test_random(300);
    idle_pct = 0;
    test_random(300);
    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/glsbfs_pkg.sv
design/glsbfs_ctrl.sv
design/glsbfs_dp.sv
design/graph_level_structure_bfs_core.sv
test/graph_level_structure_bfs_core_tb.sv
